@@ hdl/dfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the seven-bit packet deframer
// Symbol codes, result item layout, end status codes and queue sizing.
// ----------------------------------------------------------------------------
package dfr_pkg;

    // Field widths of one symbol and one result item
    localparam int SYMBOL_W = 8;
    localparam int ID_W     = 6;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Top two bits of a symbol; data symbols have bit 7 clear
    localparam logic [1:0] CODE_START = 2'b10;
    localparam logic [1:0] CODE_STOP  = 2'b11;

    // Payload bits carried by one data symbol
    localparam logic [2:0] BITS_PER_SYMBOL = 3'd7;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_GOOD     = 2'd0,
        ST_BAD      = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_RESTART  = 2'd3
    } status_t;

    // One result item as it travels through the queue
    typedef struct packed
    {
        kind_t               item_kind;
        logic [ID_W-1:0]     packet_id;
        logic [BYTE_W-1:0]   data_byte;
        logic [COUNT_W-1:0]  byte_count;
        status_t             end_status;
    } item_t;

    // Queue status seen by front and back
    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

@@ hdl/dfr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_if: valid/ready channels of the deframer
// dfr_sym_if carries received line symbols, dfr_item_if carries results.
// ----------------------------------------------------------------------------
interface dfr_sym_if;
    import dfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface dfr_item_if;
    import dfr_pkg::*;

    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [ID_W-1:0]     packet_id;
    logic [BYTE_W-1:0]   data_byte;
    logic [COUNT_W-1:0]  byte_count;
    logic [STATUS_W-1:0] end_status;

    modport source (output valid, output item_kind, output packet_id, output data_byte,
                    output byte_count, output end_status, input ready);
    modport sink   (input valid, input item_kind, input packet_id, input data_byte,
                    input byte_count, input end_status, output ready);
endinterface
`default_nettype wire

@@ hdl/dfr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_front: symbol classifier and packet state
// Accepts one symbol a cycle while the queue has room, tracks the packet,
// unpacks seven-bit groups into bytes and pushes result items.
// ----------------------------------------------------------------------------
module dfr_front #(
    parameter int MAX_BYTES = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    dfr_sym_if.sink                symbols,
    input  wire dfr_pkg::q_stat_t  q_stat,
    output logic                   push,
    output dfr_pkg::item_t         push_item
);
    import dfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BYTES);

    logic              in_pkt_reg,   in_pkt_next;
    logic [ID_W-1:0]   id_reg,       id_next;
    logic [ID_W-1:0]   sum_reg,      sum_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [2:0]        phase_reg,    phase_next;
    logic [BYTE_W-1:0] carry_reg,    carry_next;

    logic              accept;
    logic [1:0]        sym_code;
    logic [3:0]        shl;
    logic [2:0]        shr;

    assign symbols.ready = !q_stat.full;
    assign accept        = symbols.valid && !q_stat.full;
    assign sym_code      = symbols.symbol[7:6];
    assign shl           = {1'b0, phase_reg} + 4'd1;
    assign shr           = BITS_PER_SYMBOL - phase_reg;

    // Next packet state and the result item for this beat
    always_comb
    begin
        in_pkt_next = in_pkt_reg;
        id_next     = id_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        carry_next  = carry_reg;
        push        = 1'b0;

        push_item.item_kind  = KIND_END;
        push_item.packet_id  = id_reg;
        push_item.data_byte  = '0;
        push_item.byte_count = COUNT_W'(cnt_reg);
        push_item.end_status = ST_GOOD;

        if (accept)
        begin
            case (sym_code) inside
                CODE_START:
                begin
                    // restart reports the old packet before opening the new one
                    if (in_pkt_reg)
                    begin
                        push                 = 1'b1;
                        push_item.end_status = ST_RESTART;
                    end
                    in_pkt_next = 1'b1;
                    id_next     = symbols.symbol[ID_W-1:0];
                    sum_next    = symbols.symbol[ID_W-1:0];
                    cnt_next    = '0;
                    phase_next  = '0;
                    carry_next  = '0;
                end
                CODE_STOP:
                begin
                    if (in_pkt_reg)
                    begin
                        push                 = 1'b1;
                        in_pkt_next          = 1'b0;
                        push_item.end_status = (sum_reg == symbols.symbol[ID_W-1:0]) ?
                                               ST_GOOD : ST_BAD;
                    end
                end
                2'b0?:
                begin
                    if (in_pkt_reg)
                    begin
                        if (cnt_reg >= CNT_LIMIT)
                        begin
                            // length limit reached: drop the packet
                            push                 = 1'b1;
                            in_pkt_next          = 1'b0;
                            push_item.end_status = ST_OVERFLOW;
                        end
                        else
                        begin
                            sum_next   = sum_reg + symbols.symbol[ID_W-1:0];
                            carry_next = symbols.symbol << shl;
                            phase_next = phase_reg + 3'd1;
                            if (phase_reg != 3'd0)
                            begin
                                cnt_next             = cnt_reg + CNT_W'(1);
                                push                 = 1'b1;
                                push_item.item_kind  = KIND_DATA;
                                push_item.data_byte  = (symbols.symbol >> shr) | carry_reg;
                                push_item.byte_count = COUNT_W'(cnt_next);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Packet state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pkt_reg <= 1'b0;
            id_reg     <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            phase_reg  <= '0;
            carry_reg  <= '0;
        end
        else
        begin
            in_pkt_reg <= in_pkt_next;
            id_reg     <= id_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
            carry_reg  <= carry_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/dfr_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_queue: short item queue between front and back
// Circular buffer of QUEUE_DEPTH items with a fill count.
// ----------------------------------------------------------------------------
module dfr_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire dfr_pkg::item_t    push_item,
    input  wire                    pop,
    output dfr_pkg::item_t         head_item,
    output dfr_pkg::q_stat_t       q_stat
);
    import dfr_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg,   fill_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_item    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Item storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ hdl/dfr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_back: result output stage
// Pulls items from the queue into the output register and hands them out.
// ----------------------------------------------------------------------------
module dfr_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire dfr_pkg::item_t    head_item,
    input  wire dfr_pkg::q_stat_t  q_stat,
    output logic                   pop,
    dfr_item_if.source             items
);
    import dfr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Load a new item when the output register is free or being drained
    assign pop = !q_stat.empty && (!valid_reg || items.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || items.ready)
        begin
            valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head_item;
        end
    end

    assign items.valid      = valid_reg;
    assign items.item_kind  = item_reg.item_kind;
    assign items.packet_id  = item_reg.packet_id;
    assign items.data_byte  = item_reg.data_byte;
    assign items.byte_count = item_reg.byte_count;
    assign items.end_status = item_reg.end_status;

endmodule
`default_nettype wire

@@ hdl/seven_bit_packet_deframer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// seven_bit_packet_deframer_core: packet deframer for seven-bit line symbols
// Recovers packets from start, data and stop symbols and emits bytes and
// end-of-packet status items.
// ----------------------------------------------------------------------------
// The block takes one symbol per clock cycle while the queue has room and
// updates its packet state in that same cycle; each symbol yields at most
// one result item (a payload byte or an end item carrying good/bad checksum,
// overflow or restart). Results pass through a two-entry queue and an output
// register: an item is written into the queue at its symbol beat, then moved
// into the output register, where the sink takes it. While the sink stalls,
// the block keeps accepting symbols until the queue is full; the sustained
// rate is one symbol per cycle whenever the sink takes one item per cycle.
// MAX_BYTES sets the payload length limit; counts above 127 wrap in byte_count.
// ----------------------------------------------------------------------------
module seven_bit_packet_deframer_core #(
    parameter int MAX_BYTES = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    dfr_sym_if.sink     symbols,
    dfr_item_if.source  items
);
    import dfr_pkg::*;

    q_stat_t q_stat;
    item_t   push_item;
    item_t   head_item;
    logic    push;
    logic    pop;

    dfr_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbols   (symbols),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    dfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    dfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .items     (items)
    );

endmodule
`default_nettype wire
